FILE: design/dccf_pkg.sv
// ============================================================================
// Draw command compact/fuse package
// Shared transaction types and queue constants for the draw command fuser.
// ============================================================================
`default_nettype none

package dccf_pkg;

    // Result queue geometry: one item may push two results in one cycle.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One incoming draw command.
    typedef struct packed {
        logic [31:0]        index_count;
        logic [31:0]        instance_count;
        logic [31:0]        first_index;
        logic signed [31:0] base_vertex;
        logic [31:0]        base_instance;
        logic               batch_end;
    } cmd_t;

    // One emitted, possibly fused, draw command.
    typedef struct packed {
        logic [31:0]        out_count;
        logic [31:0]        out_instances;
        logic [31:0]        out_first;
        logic signed [31:0] out_base_vertex;
        logic [31:0]        out_base_instance;
        logic               last_of_batch;
        logic               batch_empty;
    } res_t;

    // Results produced by one processed item, in order r0 then r1.
    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

`default_nettype wire

FILE: design/dccf_core.sv
// ============================================================================
// Draw command fuse core
// Holds the pending command, decides fuse or emit for each processed item and
// produces zero, one or two results per item.
// ============================================================================
`default_nettype none

module dccf_core
    import dccf_pkg::*;
#(
    parameter int MAX_BATCH = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  go,
    input  wire cmd_t  item,
    output push_t      push
);

    localparam int SEEN_W = $clog2(MAX_BATCH + 1);

    logic               held_valid_reg, held_valid_next;
    logic [31:0]        held_count_reg, held_count_next;
    logic [31:0]        held_instances_reg, held_instances_next;
    logic [31:0]        held_first_reg, held_first_next;
    logic signed [31:0] held_base_vertex_reg, held_base_vertex_next;
    logic [31:0]        held_base_instance_reg, held_base_instance_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;

    logic take;
    logic live;
    logic fuse;
    logic emit_old;
    res_t old_res;
    res_t flush_res;

    // Fuse decision and next held command.
    always_comb
    begin
        take = (seen_reg < SEEN_W'(MAX_BATCH));
        live = take && (item.index_count != 32'd0);
        fuse = held_valid_reg && (held_base_vertex_reg == item.base_vertex) &&
               ((held_first_reg + held_count_reg) == item.first_index);
        emit_old = live && !fuse && held_valid_reg;

        held_valid_next         = held_valid_reg;
        held_count_next         = held_count_reg;
        held_instances_next     = held_instances_reg;
        held_first_next         = held_first_reg;
        held_base_vertex_next   = held_base_vertex_reg;
        held_base_instance_next = held_base_instance_reg;
        seen_next               = seen_reg;

        if (take)
        begin
            seen_next = seen_reg + SEEN_W'(1);
        end
        if (live)
        begin
            held_valid_next = 1'b1;
            if (fuse)
            begin
                held_count_next = held_count_reg + item.index_count;
            end
            else
            begin
                held_count_next         = item.index_count;
                held_instances_next     = item.instance_count;
                held_first_next         = item.first_index;
                held_base_vertex_next   = item.base_vertex;
                held_base_instance_next = item.base_instance;
            end
        end
    end

    // Result records: the displaced command and the end-of-batch flush.
    always_comb
    begin
        old_res.out_count         = held_count_reg;
        old_res.out_instances     = held_instances_reg;
        old_res.out_first         = held_first_reg;
        old_res.out_base_vertex   = held_base_vertex_reg;
        old_res.out_base_instance = held_base_instance_reg;
        old_res.last_of_batch     = 1'b0;
        old_res.batch_empty       = 1'b0;

        if (held_valid_next)
        begin
            flush_res.out_count         = held_count_next;
            flush_res.out_instances     = held_instances_next;
            flush_res.out_first         = held_first_next;
            flush_res.out_base_vertex   = held_base_vertex_next;
            flush_res.out_base_instance = held_base_instance_next;
            flush_res.batch_empty       = 1'b0;
        end
        else
        begin
            flush_res.out_count         = 32'd0;
            flush_res.out_instances     = 32'd0;
            flush_res.out_first         = 32'd0;
            flush_res.out_base_vertex   = 32'sd0;
            flush_res.out_base_instance = 32'd0;
            flush_res.batch_empty       = 1'b1;
        end
        flush_res.last_of_batch = 1'b1;

        push.num = 2'd0;
        push.r0  = emit_old ? old_res : flush_res;
        push.r1  = flush_res;
        if (go)
        begin
            push.num = {1'b0, emit_old} + {1'b0, item.batch_end};
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            seen_reg       <= '0;
        end
        else if (go)
        begin
            if (item.batch_end)
            begin
                held_valid_reg <= 1'b0;
                seen_reg       <= '0;
            end
            else
            begin
                held_valid_reg <= held_valid_next;
                seen_reg       <= seen_next;
            end
        end
    end

    // Held command payload.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            held_count_reg         <= held_count_next;
            held_instances_reg     <= held_instances_next;
            held_first_reg         <= held_first_next;
            held_base_vertex_reg   <= held_base_vertex_next;
            held_base_instance_reg <= held_base_instance_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dccf_queue.sv
// ============================================================================
// Result queue
// Small register queue that takes up to two results per cycle and delivers
// one result per cycle on the output channel when res_stall is low.
// ============================================================================
`default_nettype none

module dccf_queue
    import dccf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic [QCNT_W-1:0] level,
    output logic       res_valid,
    input  wire logic  res_stall,
    output res_t       res
);

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    // Pointer and occupancy update.
    always_comb
    begin
        res_valid  = (count_reg != '0);
        pop        = res_valid && !res_stall;
        wr_next    = wr_reg + QPTR_W'(push.num);
        rd_next    = rd_reg + QPTR_W'(pop);
        count_next = count_reg + QCNT_W'(push.num) - QCNT_W'(pop);
        room       = (count_reg <= QCNT_W'(QDEPTH - 2));
        res        = mem[rd_reg];
        level      = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Storage writes: first result at the write pointer, second one after it.
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_reg + QPTR_W'(1)] <= push.r1;
        end
    end

endmodule

`default_nettype wire

FILE: design/draw_command_compact_fuse_unit.sv
// A command accepted into the input register is processed once the queue has
// room for two results; its results then queue behind any earlier results.
// Throughput: one command per cycle while results drain at one per cycle; an item
// that ends a batch and also displaces a held command pushes two results.
// Reset: asynchronous, active low; clears the held command, batch count and queue.
// ============================================================================
// Draw command compact/fuse unit
// Drops empty/over-limit draws, fuses adjacent same-vertex ones, flushes batches.
// ============================================================================
`default_nettype none

module draw_command_compact_fuse_unit
    import dccf_pkg::*;
#(
    parameter int MAX_BATCH = 1024
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    cmd_t              cmd_reg;
    logic              cmd_full_reg, cmd_full_next;
    logic              accept;
    logic              go;
    logic              room;
    logic [QCNT_W-1:0] level;
    push_t             push;

    // Input stage: an item is processed once the queue has space for two results.
    always_comb
    begin
        go            = cmd_full_reg && room;
        cmd_stall     = cmd_full_reg && !room;
        accept        = cmd_valid && !cmd_stall;
        cmd_full_next = accept || (cmd_full_reg && !go);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg <= 1'b0;
        end
        else
        begin
            cmd_full_reg <= cmd_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    dccf_core #(
        .MAX_BATCH (MAX_BATCH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (cmd_reg),
        .push  (push)
    );

    dccf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .level     (level),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef ASSERT_OFF
    // The queue never holds more results than it has entries.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // Processing only happens with space for two results.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> room)
        else $error("results pushed without queue space");

    // An empty-batch result is the last of its batch and carries zero fields.
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.batch_empty) |->
            (res.last_of_batch && res.out_count == 32'd0 && res.out_first == 32'd0))
        else $error("malformed empty-batch result");

    // A pushed pair always ends with the batch flush.
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> (push.r1.last_of_batch && !push.r0.last_of_batch))
        else $error("two results pushed without a batch flush");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/draw_fuse_checker.sv
// ============================================================================
// Draw command fuse checker
// Watches both channels of the fuse unit, predicts the emitted draw commands
// of every accepted transaction and compares each result field by field.
// ============================================================================

module draw_fuse_checker
    import dccf_pkg::*;
#(
    parameter int MAX_BATCH = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res,
    output int   mismatches,
    output int   outstanding,
    output int   results_seen
);

    // Predicted draw commands, oldest first.
    res_t expected_draws[$];

    // Shadow of the pending command and the batch position.
    logic held_valid  = 1'b0;
    res_t held_draw   = '0;
    int   batch_items = 0;

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    // Apply one accepted command to the shadow state and queue what it emits.
    task automatic fuse_command(input cmd_t c);
        res_t        flushed;
        logic [31:0] next_first;
        next_first = held_draw.out_first + held_draw.out_count;
        if (batch_items < MAX_BATCH)
        begin
            batch_items++;
            if (c.index_count != 32'd0)
            begin
                if (held_valid && held_draw.out_base_vertex == c.base_vertex &&
                    next_first == c.first_index)
                begin
                    held_draw.out_count = held_draw.out_count + c.index_count;
                end
                else
                begin
                    if (held_valid)
                        expected_draws.push_back(held_draw);
                    held_valid                  = 1'b1;
                    held_draw                   = '0;
                    held_draw.out_count         = c.index_count;
                    held_draw.out_instances     = c.instance_count;
                    held_draw.out_first         = c.first_index;
                    held_draw.out_base_vertex   = c.base_vertex;
                    held_draw.out_base_instance = c.base_instance;
                end
            end
        end
        // The batch end flushes the held command, or reports an empty batch.
        if (c.batch_end)
        begin
            if (held_valid)
            begin
                flushed = held_draw;
            end
            else
            begin
                flushed             = '0;
                flushed.batch_empty = 1'b1;
            end
            flushed.last_of_batch = 1'b1;
            expected_draws.push_back(flushed);
            held_valid  = 1'b0;
            batch_items = 0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_draw(input res_t got);
        res_t want;
        results_seen++;
        if (expected_draws.size() == 0)
        begin
            $display("%0t: unexpected result, expected nothing, actual %h", $time, got);
            mismatches++;
        end
        else
        begin
            want = expected_draws.pop_front();
            compare_field("out_count", want.out_count, got.out_count);
            compare_field("out_instances", want.out_instances, got.out_instances);
            compare_field("out_first", want.out_first, got.out_first);
            compare_field("out_base_vertex", want.out_base_vertex, got.out_base_vertex);
            compare_field("out_base_instance", want.out_base_instance,
                          got.out_base_instance);
            compare_field("last_of_batch", {31'd0, want.last_of_batch},
                          {31'd0, got.last_of_batch});
            compare_field("batch_empty", {31'd0, want.batch_empty},
                          {31'd0, got.batch_empty});
        end
    endtask

    // Sample both channels at the rising edge; predict before comparing.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                fuse_command(cmd);
            if (res_valid && !res_stall)
                check_draw(res);
            outstanding = expected_draws.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// ============================================================================
// Draw command fuse unit testbench
// Drives directed and random batches of draw commands with random idling and
// a long result hold-off; the checker predicts and compares every result.
// ============================================================================

module testbench;
    import dccf_pkg::*;

    localparam int MAX_BATCH = 1024;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    int mismatch_count;
    int outstanding;
    int results_seen;

    // Stimulus controls, written by the stimulus process only.
    logic idle_on       = 1'b1;
    int   hold_request  = 0;
    int   commands_sent = 0;
    int   batches_sent  = 0;

    draw_command_compact_fuse_unit #(.MAX_BATCH(MAX_BATCH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    draw_fuse_checker #(.MAX_BATCH(MAX_BATCH)) fuse_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .mismatches   (mismatch_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one transaction at the falling edge and hold it until accepted.
    task automatic send_cmd(input cmd_t c);
        if (idle_on && $urandom_range(0, 99) < 9)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
        commands_sent++;
        if (c.batch_end)
            batches_sent++;
    endtask

    task automatic send_fields(input logic [31:0] count, input logic [31:0] instances,
                               input logic [31:0] first, input logic [31:0] vertex,
                               input logic [31:0] base_inst, input logic last);
        cmd_t c;
        c.index_count    = count;
        c.instance_count = instances;
        c.first_index    = first;
        c.base_vertex    = vertex;
        c.base_instance  = base_inst;
        c.batch_end      = last;
        send_cmd(c);
    endtask

    // One batch of random commands, mostly chained so that they fuse.
    task automatic send_random_batch(input int len);
        cmd_t               c;
        int                 kind;
        logic               have_prev;
        logic [31:0]        chain_first;
        logic signed [31:0] chain_vertex;
        have_prev    = 1'b0;
        chain_first  = '0;
        chain_vertex = '0;
        for (int i = 0; i < len; i++)
        begin
            kind             = $urandom_range(0, 99);
            c.index_count    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 64);
            c.instance_count = $urandom;
            c.base_instance  = $urandom;
            c.first_index    = $urandom;
            c.base_vertex    = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 3) - 2;
            c.batch_end      = (i == len - 1);
            if (kind < 55 && have_prev)
            begin
                c.first_index = chain_first;
                c.base_vertex = chain_vertex;
            end
            else if (kind < 67)
            begin
                c.index_count = '0;
            end
            // A few stray batch ends break a chain early.
            if (kind >= 97)
                c.batch_end = 1'b1;
            if (c.index_count != 32'd0)
            begin
                have_prev    = 1'b1;
                chain_first  = c.first_index + c.index_count;
                chain_vertex = c.base_vertex;
            end
            if (c.batch_end)
                have_prev = 1'b0;
            send_cmd(c);
        end
    endtask

    // Result side: random stalls plus one long hold-off on request.
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != holds_served)
            begin
                holds_served = hold_request;
                hold_left    = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= idle_on && ($urandom_range(0, 99) < 9);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        cmd_t        c;
        logic [31:0] next_first;
        int          random_items;
        int          drain_cycles;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty batch, then a lone command with every field at its top value.
        send_fields(32'd0, 32'd5, 32'd7, 32'd0, 32'd9, 1'b1);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 1'b1);

        // Fusing chain with a dropped command, a vertex change, and an end
        // item that displaces the held command.
        send_fields(32'd50, 32'd3, 32'd100, -32'sd5, 32'd11, 1'b0);
        send_fields(32'd10, 32'd4, 32'd150, -32'sd5, 32'd12, 1'b0);
        send_fields(32'd0, 32'd8, 32'd999, -32'sd5, 32'd12, 1'b0);
        send_fields(32'd20, 32'd1, 32'd160, -32'sd5, 32'd13, 1'b0);
        send_fields(32'd7, 32'd2, 32'd180, -32'sd6, 32'd14, 1'b0);
        send_fields(32'd7, 32'd2, 32'd187, -32'sd6, 32'd15, 1'b0);
        send_fields(32'd9, 32'd9, 32'd300, -32'sd6, 32'd0, 1'b1);

        // Address wrap and count wrap, flushed by a zero-count end item.
        send_fields(32'h20, 32'd1, 32'hFFFF_FFF0, 32'h8000_0000, 32'd1, 1'b0);
        send_fields(32'd5, 32'd1, 32'h10, 32'h8000_0000, 32'd2, 1'b0);
        send_fields(32'hFFFF_FFFF, 32'd1, 32'h15, 32'h8000_0000, 32'd3, 1'b0);
        send_fields(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);

        // Gap, then contiguous but with a different vertex: nothing fuses.
        send_fields(32'd4, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        send_fields(32'd4, 32'd1, 32'd5, 32'd0, 32'd0, 1'b0);
        send_fields(32'd4, 32'd1, 32'd9, 32'd1, 32'd0, 1'b1);

        // Batch of dropped commands only, and a lone one-index command, other fields zero.
        send_fields(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0);
        send_fields(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        send_fields(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);

        // Oversized batch: commands past the limit must be ignored.
        next_first = 32'd0;
        for (int i = 0; i < MAX_BATCH + 6; i++)
        begin
            c.index_count    = $urandom_range(1, 8);
            c.instance_count = $urandom;
            c.base_instance  = $urandom;
            c.base_vertex    = 32'sd3;
            c.first_index    = (i % 100 == 99 || i >= MAX_BATCH) ? next_first + 32'd1000
                                                                : next_first;
            c.batch_end      = (i == MAX_BATCH + 5);
            next_first       = c.first_index + c.index_count;
            send_cmd(c);
        end

        // Random batches with a quiet stretch and one long result hold-off.
        random_items = 0;
        while (random_items < 600)
        begin
            if (random_items >= 150 && hold_request == 0)
                hold_request <= 1;
            idle_on <= !(random_items >= 300 && random_items < 420);
            c.batch_end = 1'b0;
            send_random_batch($urandom_range(1, 12));
            random_items = commands_sent - 19 - (MAX_BATCH + 6);
        end
        cmd_valid <= 1'b0;

        // Drain every predicted result, then allow the pipeline to settle.
        drain_cycles = 0;
        while (outstanding != 0 && drain_cycles < 5000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (10) @(negedge clk);

        $display("Sent %0d commands in %0d batches, one past the batch limit.",
                 commands_sent, batches_sent);
        $display("Checked %0d results over fusing, drops, empty batches and wraps.",
                 results_seen);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/dccf_pkg.sv
design/dccf_core.sv
design/dccf_queue.sv
design/draw_command_compact_fuse_unit.sv
tb/sv/draw_fuse_checker.sv
tb/sv/testbench.sv
